### sv/joystick_inactivity_alarm_assert.svh
// ----------------------------------------------------------------------------
// joystick inactivity alarm assertion macros
// property forms for the checker file of the alarm block
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_INACTIVITY_ALARM_ASSERT_SVH
`define JOYSTICK_INACTIVITY_ALARM_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define JIA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define JIA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/jia_pkg.sv
// ----------------------------------------------------------------------------
// jia_pkg
// types, codes and reset values shared by the joystick inactivity alarm
// ----------------------------------------------------------------------------
package jia_pkg;

	localparam int AXIS_W     = 12;
	localparam int IDLE_W     = 16;
	localparam int WIN_W      = 24;
	localparam int TIME_W     = 32;
	localparam int PRESS_W    = 3;
	localparam int KIND_W     = 2;
	localparam int PERIOD_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// event kinds
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RESET  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMERG  = 2'd2;

	// next sample period codes
	localparam logic [PERIOD_W-1:0] PERIOD_2000MS = 2'd0;
	localparam logic [PERIOD_W-1:0] PERIOD_500MS  = 2'd1;
	localparam logic [PERIOD_W-1:0] PERIOD_1000MS = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAFE_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAFE_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_IDLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RED_IDLE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BUZZ_IDLE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_WIN = 3'd6;

	// register reset values
	localparam logic [AXIS_W-1:0] DEADZONE_RST  = 12'd100;
	localparam logic [AXIS_W-1:0] SAFE_LOW_RST  = 12'd700;
	localparam logic [AXIS_W-1:0] SAFE_HIGH_RST = 12'd3300;
	localparam logic [IDLE_W-1:0] BLUE_IDLE_RST = 16'd30;
	localparam logic [IDLE_W-1:0] RED_IDLE_RST  = 16'd45;
	localparam logic [IDLE_W-1:0] BUZZ_IDLE_RST = 16'd60;
	localparam logic [WIN_W-1:0]  PRESS_WIN_RST = 24'd500000;

	localparam logic [AXIS_W-1:0]  AXIS_CENTER = 12'd2048;
	localparam logic [IDLE_W-1:0]  IDLE_MAX    = 16'hFFFF;
	localparam logic [PRESS_W-1:0] PRESS_MAX   = 3'd7;
	localparam logic [PRESS_W-1:0] PRESS_ON    = 3'd2;
	localparam logic [PRESS_W-1:0] PRESS_OFF   = 3'd3;

	typedef struct packed {
		logic [AXIS_W-1:0] deadzone;
		logic [AXIS_W-1:0] safe_low;
		logic [AXIS_W-1:0] safe_high;
		logic [IDLE_W-1:0] blue_idle_samples;
		logic [IDLE_W-1:0] red_idle_samples;
		logic [IDLE_W-1:0] buzz_idle_samples;
		logic [WIN_W-1:0]  press_window_us;
	} cfg_t;

endpackage

### sv/jia_cfg_regs.sv
// ----------------------------------------------------------------------------
// jia_cfg_regs
// configuration register file, decodes writes by register index
// ----------------------------------------------------------------------------
module jia_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [jia_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [jia_pkg::CFG_DATA_W-1:0] wr_data,
	output jia_pkg::cfg_t                  cfg
);
	import jia_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone          <= DEADZONE_RST;
			cfg_q.safe_low          <= SAFE_LOW_RST;
			cfg_q.safe_high         <= SAFE_HIGH_RST;
			cfg_q.blue_idle_samples <= BLUE_IDLE_RST;
			cfg_q.red_idle_samples  <= RED_IDLE_RST;
			cfg_q.buzz_idle_samples <= BUZZ_IDLE_RST;
			cfg_q.press_window_us   <= PRESS_WIN_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DEADZONE:  cfg_q.deadzone          <= wr_data[AXIS_W-1:0];
				REG_SAFE_LOW:  cfg_q.safe_low          <= wr_data[AXIS_W-1:0];
				REG_SAFE_HIGH: cfg_q.safe_high         <= wr_data[AXIS_W-1:0];
				REG_BLUE_IDLE: cfg_q.blue_idle_samples <= wr_data[IDLE_W-1:0];
				REG_RED_IDLE:  cfg_q.red_idle_samples  <= wr_data[IDLE_W-1:0];
				REG_BUZZ_IDLE: cfg_q.buzz_idle_samples <= wr_data[IDLE_W-1:0];
				REG_PRESS_WIN: cfg_q.press_window_us   <= wr_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/joystick_inactivity_alarm.sv
// ----------------------------------------------------------------------------
// joystick_inactivity_alarm
// joystick idle watchdog with out-of-range flashing and emergency mode
// ----------------------------------------------------------------------------
// The block takes one event per request: a joystick sample, a reset button
// press or an emergency button press. It accepts one request every clock
// cycle unless stalled and returns exactly one result per request, passed
// through one input register and one result register. The whole update of
// the alarm state for a request is computed combinationally between those
// two registers, so back-to-back requests see each other's effects in order.
// The input side keeps accepting while a finished result waits on the output;
// it stalls only when both the input and the result register are full and
// out_ready is low. Configuration writes are always accepted (cfg_ready is
// tied high) and must only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module joystick_inactivity_alarm (
	input  logic                           clk,
	input  logic                           arst_n,

	// event requests
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [jia_pkg::KIND_W-1:0]     kind,
	input  logic [jia_pkg::AXIS_W-1:0]     joy_x,
	input  logic [jia_pkg::AXIS_W-1:0]     joy_y,
	input  logic [jia_pkg::TIME_W-1:0]     now_us,

	// results
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           green_led,
	output logic                           red_led,
	output logic                           buzzer_sound,
	output logic                           blue_blink,
	output logic                           show_alert,
	output logic                           emergency,
	output logic [jia_pkg::PERIOD_W-1:0]   period_code,

	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [jia_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jia_pkg::CFG_DATA_W-1:0] cfg_data
);
	import jia_pkg::*;

	cfg_t cfg;

	// input register
	logic                v_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [AXIS_W-1:0]   x_s1;
	logic [AXIS_W-1:0]   y_s1;
	logic [TIME_W-1:0]   now_s1;

	// alarm state
	logic [AXIS_W-1:0]   prev_x_q;
	logic [AXIS_W-1:0]   prev_y_q;
	logic [IDLE_W-1:0]   idle_q;
	logic                red_alert_q;
	logic                buzzer_on_q;
	logic                beep_phase_q;
	logic                tone_level_q;
	logic                green_q;
	logic                red_q;
	logic [PRESS_W-1:0]  press_cnt_q;
	logic                emerg_q;
	logic [TIME_W-1:0]   last_press_q;

	// next state
	logic [AXIS_W-1:0]   prev_x_d;
	logic [AXIS_W-1:0]   prev_y_d;
	logic [IDLE_W-1:0]   idle_d;
	logic                red_alert_d;
	logic                buzzer_on_d;
	logic                beep_phase_d;
	logic                tone_level_d;
	logic                green_d;
	logic                red_d;
	logic [PRESS_W-1:0]  press_cnt_d;
	logic                emerg_d;
	logic [TIME_W-1:0]   last_press_d;
	logic                blink_d;
	logic                alert_d;
	logic [PERIOD_W-1:0] period_d;

	// result register
	logic                out_valid_q;
	logic                green_led_q;
	logic                red_led_q;
	logic                buzzer_sound_q;
	logic                blue_blink_q;
	logic                show_alert_q;
	logic                emergency_q;
	logic [PERIOD_W-1:0] period_code_q;

	// sample decode helpers
	logic [AXIS_W-1:0]   dx;
	logic [AXIS_W-1:0]   dy;
	logic                moved;
	logic                out_of_range;
	logic [TIME_W-1:0]   gap;
	logic                in_window;
	logic                advance;

	jia_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;

	// result register frees up when empty or when its result is taken
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !v_s1 || advance;

	// per-axis distance from the remembered position
	assign dx    = (x_s1 > prev_x_q) ? (x_s1 - prev_x_q) : (prev_x_q - x_s1);
	assign dy    = (y_s1 > prev_y_q) ? (y_s1 - prev_y_q) : (prev_y_q - y_s1);
	assign moved = (dx > cfg.deadzone) || (dy > cfg.deadzone);

	assign out_of_range = (x_s1 < cfg.safe_low) || (x_s1 > cfg.safe_high) ||
	                      (y_s1 < cfg.safe_low) || (y_s1 > cfg.safe_high);

	// wrapping time since the previous emergency press
	assign gap       = now_s1 - last_press_q;
	assign in_window = gap < {{(TIME_W-WIN_W){1'b0}}, cfg.press_window_us};

	always_comb begin
		logic fresh;
		fresh        = 1'b0;
		prev_x_d     = prev_x_q;
		prev_y_d     = prev_y_q;
		idle_d       = idle_q;
		red_alert_d  = red_alert_q;
		buzzer_on_d  = buzzer_on_q;
		beep_phase_d = beep_phase_q;
		tone_level_d = tone_level_q;
		green_d      = green_q;
		red_d        = red_q;
		press_cnt_d  = press_cnt_q;
		emerg_d      = emerg_q;
		last_press_d = last_press_q;
		blink_d      = 1'b0;
		alert_d      = 1'b0;
		period_d     = PERIOD_2000MS;

		unique case (kind_s1)
			KIND_RESET: begin
				red_alert_d = 1'b0;
				buzzer_on_d = 1'b0;
				red_d       = 1'b0;
				idle_d      = '0;
			end

			KIND_EMERG: begin
				if (in_window) begin
					if (press_cnt_q < PRESS_MAX)
						press_cnt_d = press_cnt_q + PRESS_W'(1);
				end else begin
					press_cnt_d = PRESS_W'(1);
				end
				last_press_d = now_s1;
				// two quick presses arm, three quick presses disarm
				if (!emerg_q && press_cnt_d == PRESS_ON) begin
					emerg_d = 1'b1;
				end else if (emerg_q && press_cnt_d == PRESS_OFF) begin
					emerg_d     = 1'b0;
					press_cnt_d = '0;
				end
			end

			KIND_SAMPLE: begin
				// movement clears the escalation, stillness counts up
				if (moved) begin
					idle_d      = '0;
					red_alert_d = 1'b0;
					buzzer_on_d = 1'b0;
					red_d       = 1'b0;
					prev_x_d    = x_s1;
					prev_y_d    = y_s1;
					fresh       = 1'b1;
				end else if (idle_q != IDLE_MAX) begin
					idle_d = idle_q + IDLE_W'(1);
					fresh  = 1'b1;
				end

				if (emerg_q) begin
					period_d = PERIOD_1000MS;
				end else if (out_of_range) begin
					// flash both leds and beep
					green_d = !green_q;
					red_d   = !red_d;
					if (!buzzer_on_d) begin
						buzzer_on_d  = 1'b1;
						beep_phase_d = 1'b1;
					end else begin
						beep_phase_d = !beep_phase_q;
						tone_level_d = !beep_phase_q;
					end
					period_d = PERIOD_500MS;
				end else begin
					green_d = 1'b0;
					if (!red_alert_d)
						red_d = 1'b0;
					if (buzzer_on_d && idle_d < cfg.buzz_idle_samples)
						buzzer_on_d = 1'b0;

					// blink once when the count lands on the blue threshold
					blink_d = fresh && (idle_d == cfg.blue_idle_samples);

					if (idle_d >= cfg.red_idle_samples) begin
						red_alert_d = 1'b1;
						alert_d     = 1'b1;
						red_d       = !red_d;
					end
					if (idle_d >= cfg.buzz_idle_samples && !buzzer_on_d) begin
						buzzer_on_d  = 1'b1;
						beep_phase_d = 1'b1;
					end
					if (buzzer_on_d) begin
						beep_phase_d = !beep_phase_d;
						tone_level_d = beep_phase_d;
						period_d     = PERIOD_500MS;
					end
					if (red_alert_d && !buzzer_on_d)
						period_d = PERIOD_500MS;
				end
			end

			default: ; // unused kind leaves state alone
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			x_s1    <= joy_x;
			y_s1    <= joy_y;
			now_s1  <= now_us;
		end
	end

	// alarm state commits when the request moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q     <= AXIS_CENTER;
			prev_y_q     <= AXIS_CENTER;
			idle_q       <= '0;
			red_alert_q  <= 1'b0;
			buzzer_on_q  <= 1'b0;
			beep_phase_q <= 1'b0;
			tone_level_q <= 1'b1;
			green_q      <= 1'b0;
			red_q        <= 1'b0;
			press_cnt_q  <= '0;
			emerg_q      <= 1'b0;
			last_press_q <= '0;
		end else if (advance && v_s1) begin
			prev_x_q     <= prev_x_d;
			prev_y_q     <= prev_y_d;
			idle_q       <= idle_d;
			red_alert_q  <= red_alert_d;
			buzzer_on_q  <= buzzer_on_d;
			beep_phase_q <= beep_phase_d;
			tone_level_q <= tone_level_d;
			green_q      <= green_d;
			red_q        <= red_d;
			press_cnt_q  <= press_cnt_d;
			emerg_q      <= emerg_d;
			last_press_q <= last_press_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			green_led_q    <= green_d;
			red_led_q      <= red_d;
			buzzer_sound_q <= buzzer_on_d && tone_level_d;
			blue_blink_q   <= blink_d;
			show_alert_q   <= alert_d;
			emergency_q    <= emerg_d;
			period_code_q  <= period_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign green_led    = green_led_q;
	assign red_led      = red_led_q;
	assign buzzer_sound = buzzer_sound_q;
	assign blue_blink   = blue_blink_q;
	assign show_alert   = show_alert_q;
	assign emergency    = emergency_q;
	assign period_code  = period_code_q;

endmodule

### sv/jia_checker.sv
// ----------------------------------------------------------------------------
// jia_checker
// port-level checks on the alarm results, bound to the top level
// ----------------------------------------------------------------------------
`include "joystick_inactivity_alarm_assert.svh"

module jia_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         green_led,
	input logic                         red_led,
	input logic                         buzzer_sound,
	input logic                         blue_blink,
	input logic                         show_alert,
	input logic                         emergency,
	input logic [jia_pkg::PERIOD_W-1:0] period_code
);
	import jia_pkg::*;

	// the alert message always goes with the fast period
	`JIA_ASSERT_IMP(a_alert_fast, clk, arst_n, out_valid && show_alert, period_code == PERIOD_500MS, "alert result without fast period")

	// in emergency mode no escalation pulses come out
	`JIA_ASSERT_IMP(a_emerg_quiet, clk, arst_n, out_valid && emergency, !blue_blink && !show_alert, "escalation pulse during emergency mode")

	// a stalled result holds
	`JIA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({green_led, red_led, buzzer_sound, blue_blink, show_alert, emergency, period_code}), "stalled result changed")

	// only the three defined period codes are produced
	`JIA_ASSERT_IMP(a_period_code, clk, arst_n, out_valid, period_code == PERIOD_2000MS || period_code == PERIOD_500MS || period_code == PERIOD_1000MS, "undefined period code")

endmodule

bind joystick_inactivity_alarm jia_checker u_jia_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.green_led    (green_led),
	.red_led      (red_led),
	.buzzer_sound (buzzer_sound),
	.blue_blink   (blue_blink),
	.show_alert   (show_alert),
	.emergency    (emergency),
	.period_code  (period_code)
);
